/* design/rms_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers of the reward modulated stdp synapse
// no dependencies

package rms_pkg;

    localparam int W_BITS   = 8;                      // synaptic weight
    localparam int T_BITS   = 32;                     // spike tick
    localparam int TR_BITS  = 7;                      // eligibility trace
    localparam int RW_BITS  = 16;                     // reward amount
    localparam int SC_BITS  = 16;                     // reward scale
    localparam int WIN_BITS = 8;                      // stdp window
    localparam int OP_BITS  = 3;
    localparam int SUM_W    = W_BITS + 2;             // weight plus a limited step
    localparam int PROD_W   = TR_BITS + 1 + RW_BITS;  // signed trace times reward
    localparam int DIV_W    = PROD_W;                 // dividend magnitude
    localparam int DCNT_W   = $clog2(DIV_W + 1);
    localparam int LIM_BITS = 5;
    localparam logic [LIM_BITS-1:0] STEP_LIMIT = 5'd16;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_INIT   = 3'd0,
        OP_MARK   = 3'd1,
        OP_STDP   = 3'd2,
        OP_DECAY  = 3'd3,
        OP_REWARD = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        REG_WMIN  = 3'd0,
        REG_WMAX  = 3'd1,
        REG_WIN   = 3'd2,
        REG_EMAX  = 3'd3,
        REG_EDEC  = 3'd4,
        REG_SCALE = 3'd5
    } t_reg;

    typedef struct packed {
        logic signed [W_BITS-1:0] wmin;
        logic signed [W_BITS-1:0] wmax;
        logic [WIN_BITS-1:0]      win;
        logic [TR_BITS-1:0]       emax;
        logic [TR_BITS-1:0]       edec;
        logic [SC_BITS-1:0]       scale;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic calc_diff;
        logic eval;
        logic exec;
        logic mul;
        logic div_start;
        logic rew_apply;
        logic push;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic rew_go;
        logic div_done;
    } t_dp_stat;

    // lower limit tested first: with crossed limits a value below it gets the lower limit, any other the upper
    function automatic logic signed [W_BITS-1:0] f_clamp(
        input logic signed [SUM_W-1:0]  w,
        input logic signed [W_BITS-1:0] lo,
        input logic signed [W_BITS-1:0] hi
    );
        logic signed [SUM_W-1:0] lo_x;
        logic signed [SUM_W-1:0] hi_x;
        lo_x = SUM_W'(lo);
        hi_x = SUM_W'(hi);
        if (w < lo_x) begin
            return lo;
        end else if (w > hi_x) begin
            return hi;
        end
        return w[W_BITS-1:0];
    endfunction

endpackage

/* design/reward_modulated_stdp_synapse_core.sv */
`timescale 1ns / 1ps
// a word passes the states diff, eval and exec, and for an effective reward mul, div, wait and apply,
// then done pushes the output word; no new word is taken before that push (serial divider, 24 steps)
// the output register holds a finished word while the next input word is taken
// reset: synchronous active low; weight 0, trace 0, plastic set, registers to defaults
// depends on rms_pkg, rms_regs, rms_ctrl, rms_dp and rms_div

module reward_modulated_stdp_synapse_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rms_pkg::ADDR_W-1:0]          paddr,
    input  logic [rms_pkg::DATA_W-1:0]          pwdata,
    output logic [rms_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rms_pkg::OP_BITS-1:0]         i_op,
    input  logic signed [rms_pkg::T_BITS-1:0]   i_pre_time,
    input  logic signed [rms_pkg::T_BITS-1:0]   i_post_time,
    input  logic signed [rms_pkg::RW_BITS-1:0]  i_reward_amount,
    input  logic signed [rms_pkg::W_BITS-1:0]   i_init_weight,
    input  logic                                i_init_plastic,
    // output words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rms_pkg::W_BITS-1:0]   o_weight_out,
    output logic [rms_pkg::TR_BITS-1:0]         o_trace_out
);
    import rms_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // register accesses never wait
    assign pready = 1'b1;

    // weight limits, stdp window, trace settings and reward divisor
    rms_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // sequencer: latch word, take spike difference, test window, update state,
    // then for an effective reward multiply, divide and apply the limited step
    rms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // weight, trace and plastic flag live here, with the serial divider
    rms_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_op),
        .i_pre_time      (i_pre_time),
        .i_post_time     (i_post_time),
        .i_reward_amount (i_reward_amount),
        .i_init_weight   (i_init_weight),
        .i_init_plastic  (i_init_plastic),
        .o_weight_out    (o_weight_out),
        .o_trace_out     (o_trace_out)
    );

endmodule

/* design/rms_regs.sv */
`timescale 1ns / 1ps
// apb configuration registers of the synapse
// depends on rms_pkg

module rms_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rms_pkg::ADDR_W-1:0]  paddr,
    input  logic [rms_pkg::DATA_W-1:0]  pwdata,
    output logic [rms_pkg::DATA_W-1:0]  prdata,
    output rms_pkg::t_cfg               o_cfg
);
    import rms_pkg::*;

    t_cfg        r_cfg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wmin  <= -8'sd127;
            r_cfg.wmax  <= 8'sd127;
            r_cfg.win   <= 8'd20;
            r_cfg.emax  <= 7'd100;
            r_cfg.edec  <= 7'd1;
            r_cfg.scale <= 16'd100;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WMIN:  r_cfg.wmin  <= pwdata[W_BITS-1:0];
                REG_WMAX:  r_cfg.wmax  <= pwdata[W_BITS-1:0];
                REG_WIN:   r_cfg.win   <= pwdata[WIN_BITS-1:0];
                REG_EMAX:  r_cfg.emax  <= pwdata[TR_BITS-1:0];
                REG_EDEC:  r_cfg.edec  <= pwdata[TR_BITS-1:0];
                REG_SCALE: r_cfg.scale <= pwdata[SC_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WMIN:  prdata = DATA_W'($unsigned(r_cfg.wmin));
            REG_WMAX:  prdata = DATA_W'($unsigned(r_cfg.wmax));
            REG_WIN:   prdata = DATA_W'(r_cfg.win);
            REG_EMAX:  prdata = DATA_W'(r_cfg.emax);
            REG_EDEC:  prdata = DATA_W'(r_cfg.edec);
            REG_SCALE: prdata = DATA_W'(r_cfg.scale);
            default:   prdata = '0;
        endcase
    end

endmodule

/* design/rms_div.sv */
`timescale 1ns / 1ps
// serial restoring divider, one quotient bit per cycle
// depends on rms_pkg

module rms_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rms_pkg::DIV_W-1:0]    i_dividend,
    input  logic [rms_pkg::SC_BITS-1:0]  i_divisor,
    output logic                         o_done,
    output logic [rms_pkg::DIV_W-1:0]    o_quot
);
    import rms_pkg::*;

    logic [DCNT_W-1:0]  r_cnt;
    logic               r_done;
    logic [SC_BITS-1:0] r_rem;
    logic [DIV_W-1:0]   r_quot;
    logic [SC_BITS-1:0] r_dvs;

    logic [SC_BITS:0]   rem_sh;
    logic [SC_BITS:0]   rem_sub;
    logic               ge;
    logic [SC_BITS-1:0] n_rem;
    logic [DIV_W-1:0]   n_quot;

    always_comb begin
        rem_sh  = {r_rem, r_quot[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        ge      = (rem_sh >= {1'b0, r_dvs});
        n_rem   = ge ? rem_sub[SC_BITS-1:0] : rem_sh[SC_BITS-1:0];
        n_quot  = {r_quot[DIV_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= DCNT_W'(DIV_W);
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_cnt != '0) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* design/rms_dp.sv */
`timescale 1ns / 1ps
// synapse datapath: input word, spike timing, state, reward product and output word
// depends on rms_pkg and rms_div

module rms_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rms_pkg::t_cfg                       i_cfg,
    input  rms_pkg::t_dp_cmd                    i_cmd,
    output rms_pkg::t_dp_stat                   o_stat,
    input  logic [rms_pkg::OP_BITS-1:0]         i_op,
    input  logic signed [rms_pkg::T_BITS-1:0]   i_pre_time,
    input  logic signed [rms_pkg::T_BITS-1:0]   i_post_time,
    input  logic signed [rms_pkg::RW_BITS-1:0]  i_reward_amount,
    input  logic signed [rms_pkg::W_BITS-1:0]   i_init_weight,
    input  logic                                i_init_plastic,
    output logic signed [rms_pkg::W_BITS-1:0]   o_weight_out,
    output logic [rms_pkg::TR_BITS-1:0]         o_trace_out
);
    import rms_pkg::*;

    // latched input word
    logic [OP_BITS-1:0]         r_op;
    logic [T_BITS-1:0]          r_pre;
    logic [T_BITS-1:0]          r_post;
    logic signed [RW_BITS-1:0]  r_rew;
    logic signed [W_BITS-1:0]   r_iw;
    logic                       r_ip;

    // timing terms
    logic [T_BITS-1:0]          r_diff;
    logic                       r_in_win;
    logic                       r_pos;
    logic                       r_step;

    // synapse state
    logic signed [W_BITS-1:0]   r_weight;
    logic [TR_BITS-1:0]         r_trace;
    logic                       r_plastic;

    logic signed [PROD_W-1:0]   r_prod;
    logic signed [W_BITS-1:0]   r_out_w;
    logic [TR_BITS-1:0]         r_out_t;

    logic [T_BITS-1:0]          mag;
    logic                       in_win;
    logic [WIN_BITS:0]          win_gap;
    logic                       step_one;

    logic signed [SUM_W-1:0]    w_ext;
    logic signed [SUM_W-1:0]    stdp_sum;
    logic signed [SUM_W-1:0]    lim_x;
    logic signed [SUM_W-1:0]    delta;
    logic [LIM_BITS-1:0]        lim;
    logic [TR_BITS-1:0]         decayed;

    logic signed [W_BITS-1:0]   n_weight;
    logic [TR_BITS-1:0]         n_trace;
    logic                       n_plastic;

    logic [DIV_W-1:0]           prod_mag;
    logic [SC_BITS-1:0]         divisor;
    logic                       div_done;
    logic [DIV_W-1:0]           quot;

    // magnitude of the wrapped difference; the most negative value stays out of range
    always_comb begin
        mag      = r_diff[T_BITS-1] ? (T_BITS'(0) - r_diff) : r_diff;
        in_win   = (mag != '0) && (mag <= T_BITS'(i_cfg.win));
        win_gap  = {1'b0, i_cfg.win} - {1'b0, mag[WIN_BITS-1:0]};
        // 2*(window-|d|)/window is one exactly when 2*(window-|d|) >= window
        step_one = ({win_gap, 1'b0} >= (WIN_BITS + 2)'(i_cfg.win));
    end

    assign prod_mag = r_prod[PROD_W-1] ? DIV_W'(-r_prod) : DIV_W'(r_prod);
    assign divisor  = (i_cfg.scale == '0) ? SC_BITS'(1) : i_cfg.scale;

    rms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (prod_mag),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        w_ext    = SUM_W'(r_weight);
        stdp_sum = w_ext;
        if (r_step) begin
            stdp_sum = r_pos ? (w_ext + SUM_W'(1)) : (w_ext - SUM_W'(1));
        end
        decayed = (r_trace > i_cfg.edec) ? (r_trace - i_cfg.edec) : '0;

        lim   = (quot > DIV_W'(STEP_LIMIT)) ? STEP_LIMIT : quot[LIM_BITS-1:0];
        lim_x = signed'(SUM_W'(lim));
        delta = r_prod[PROD_W-1] ? -lim_x : lim_x;

        n_weight  = r_weight;
        n_trace   = r_trace;
        n_plastic = r_plastic;
        if (i_cmd.exec) begin
            case (r_op)
                OP_INIT: begin
                    n_weight  = f_clamp(SUM_W'(r_iw), i_cfg.wmin, i_cfg.wmax);
                    n_plastic = r_ip;
                    n_trace   = '0;
                end
                OP_MARK: begin
                    if (r_plastic && r_pos && r_in_win) begin
                        n_trace = i_cfg.emax;
                    end
                end
                OP_STDP: begin
                    if (r_plastic && r_in_win) begin
                        n_weight = f_clamp(stdp_sum, i_cfg.wmin, i_cfg.wmax);
                    end
                end
                OP_DECAY: n_trace = decayed;
                default: ;
            endcase
        end else if (i_cmd.rew_apply) begin
            n_weight = f_clamp(w_ext + delta, i_cfg.wmin, i_cfg.wmax);
            n_trace  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_op;
            r_pre  <= i_pre_time;
            r_post <= i_post_time;
            r_rew  <= i_reward_amount;
            r_iw   <= i_init_weight;
            r_ip   <= i_init_plastic;
        end
        if (i_cmd.calc_diff) begin
            r_diff <= r_post - r_pre;
        end
        if (i_cmd.eval) begin
            r_in_win <= in_win;
            r_pos    <= !r_diff[T_BITS-1] && (r_diff != '0);
            r_step   <= step_one;
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_trace}) * r_rew;
        end
        if (i_cmd.push) begin
            r_out_w <= r_weight;
            r_out_t <= r_trace;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight  <= '0;
            r_trace   <= '0;
            r_plastic <= 1'b1;
        end else begin
            r_weight  <= n_weight;
            r_trace   <= n_trace;
            r_plastic <= n_plastic;
        end
    end

    assign o_stat.rew_go   = (r_op == OP_REWARD) && r_plastic && (r_trace != '0);
    assign o_stat.div_done = div_done;
    assign o_weight_out    = r_out_w;
    assign o_trace_out     = r_out_t;

endmodule

/* design/rms_ctrl.sv */
`timescale 1ns / 1ps
// sequencing state machine and output word handshake
// depends on rms_pkg

module rms_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  rms_pkg::t_dp_stat   i_stat,
    output rms_pkg::t_dp_cmd    o_cmd
);
    import rms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_EVAL,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_WAIT,
        S_APPLY,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   push;

    assign push = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.calc_diff = (r_state == S_DIFF);
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DIV);
        o_cmd.rew_apply = (r_state == S_APPLY);
        o_cmd.push      = push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF:  r_state <= S_EVAL;
                S_EVAL:  r_state <= S_EXEC;
                S_EXEC:  r_state <= i_stat.rew_go ? S_MUL : S_DONE;
                S_MUL:   r_state <= S_DIV;
                S_DIV:   r_state <= S_WAIT;
                S_WAIT: begin
                    if (i_stat.div_done) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: r_state <= S_DONE;
                S_DONE: begin
                    if (push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
